FILE: src/assert_macros.svh
// assertion macros included by the decoder rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, quiet during rst
`define ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, sampled on clk, quiet during rst
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: src/rbcfd_pkg.sv
// shared constants, types and gain table of the command frame decoder
`default_nettype none

package rbcfd_pkg;

  // command codes
  localparam logic CMD_STORE = 1'b0;
  localparam logic CMD_POLL  = 1'b1;

  // frame layout
  localparam int unsigned FRAME_LEN    = 8;
  localparam logic [7:0]  HEADER_BYTE  = 8'h0a;
  localparam logic [7:0]  TAIL_BYTE    = 8'hff;

  // mode codes
  localparam logic [7:0]  MODE_FIXED   = 8'd1;
  localparam logic [7:0]  MODE_SCALED  = 8'd2;

  // settings arithmetic
  localparam int unsigned TABLE_SIZE     = 30;
  localparam logic [6:0]  FREQ_SCALE     = 7'd100;
  localparam logic [16:0] FULL_AMPLITUDE = 17'd1023;
  localparam int unsigned GAIN_FRAC      = 12;
  localparam int unsigned GAIN_W         = 21;

  // per-transfer status flags of a poll
  typedef struct packed {
    logic consumed;
    logic accepted;
    logic err;
  } flags_t;

  // unsigned q9.12 reciprocal of the calibration gain, 1023 / (3.3 * gain)
  function automatic logic [GAIN_W-1:0] gain_recip(input logic [4:0] idx);
    logic [GAIN_W-1:0] g;
    case (idx)
      5'd0:  g = 21'd248000;
      5'd1:  g = 21'd260197;
      5'd2:  g = 21'd280920;
      5'd3:  g = 21'd299472;
      5'd4:  g = 21'd323918;
      5'd5:  g = 21'd348835;
      5'd6:  g = 21'd377905;
      5'd7:  g = 21'd406974;
      5'd8:  g = 21'd439363;
      5'd9:  g = 21'd472030;
      5'd10: g = 21'd507904;
      5'd11: g = 21'd547310;
      5'd12: g = 21'd587852;
      5'd13: g = 21'd622431;
      5'd14: g = 21'd661333;
      5'd15: g = 21'd705422;
      5'd16: g = 21'd755810;
      5'd17: g = 21'd793600;
      5'd18: g = 21'd840901;
      5'd19: g = 21'd887944;
      5'd20: g = 21'd933647;
      5'd21: g = 21'd992000;
      5'd22: g = 21'd1049388;
      5'd23: g = 21'd1104139;
      5'd24: g = 21'd1164917;
      5'd25: g = 21'd1220923;
      5'd26: g = 21'd1290407;
      5'd27: g = 21'd1333782;
      5'd28: g = 21'd1404602;
      5'd29: g = 21'd1483364;
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

FILE: src/rbcfd_ram.sv
// generic single-port-write, single-port-read ram with registered read
`default_nettype none

module rbcfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                                 clk,
  input  wire logic                                 we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                     wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: src/ring_buffered_command_frame_decoder.sv
// Byte store gives no result; busy stays low.
// Poll with fewer than eight bytes held: strobe in the cycle after the transfer.
// Full poll: busy through eight reads via the single ring read port, then decode
// and multiply, then update; the strobe is registered in the update state.
// Reset clears pointers, fill count and settings; ring contents are left as
// they are and need no clearing pass, since only held entries are ever read.
`default_nettype none

module ring_buffered_command_frame_decoder #(
  parameter int RING_DEPTH   = 256,
  parameter int GAIN_ENTRIES = 30
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        command,
  input  wire logic [7:0]  rx_byte,
  output logic             done,
  output logic [30:0]      frequency_word,
  output logic [16:0]      amplitude_word,
  output logic [7:0]       mode_code,
  output logic             frame_consumed,
  output logic             frame_accepted,
  output logic             index_error,
  output logic [8:0]       fill_level
);

`include "assert_macros.svh"

  localparam int PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int HW = $clog2(RING_DEPTH + 1);

  localparam logic [PW-1:0] LAST_ADDR = PW'(RING_DEPTH - 1);
  localparam logic [HW-1:0] FULL_CNT  = HW'(RING_DEPTH);
  localparam logic [HW-1:0] FRAME_CNT = HW'(rbcfd_pkg::FRAME_LEN);
  localparam logic [PW:0]   DEPTH_EXT = (PW+1)'(RING_DEPTH);
  localparam logic [PW:0]   FRAME_EXT = (PW+1)'(rbcfd_pkg::FRAME_LEN);
  localparam logic [23:0]   GAIN_MAX  = 24'(GAIN_ENTRIES);
  localparam logic [23:0]   TABLE_MAX = 24'(rbcfd_pkg::TABLE_SIZE);

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_CALC = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]    state;
  logic [PW-1:0] rd_ptr;
  logic [PW-1:0] wr_ptr;
  logic [HW-1:0] held;
  logic [PW-1:0] rd_addr;
  logic [3:0]    cnt;
  logic [7:0]    frame [rbcfd_pkg::FRAME_LEN];
  logic [7:0]    ram_rdata;
  logic          ram_we;

  logic [7:0]    cur_mode;
  logic [30:0]   cur_freq;
  logic [16:0]   cur_amp;

  logic [30:0]   freq_calc;
  logic [16:0]   amp_calc;
  logic          calc_valid;
  logic          calc_range;
  logic [7:0]    calc_mode;

  rbcfd_pkg::flags_t flags;

  logic          xfer;
  logic [23:0]   count;
  logic          hdr_ok;
  logic          in_range;
  logic [28:0]   amp_prod;
  logic [PW:0]   rd_ptr_sum;

  assign busy = (state != ST_IDLE);
  assign xfer = start && !busy;
  assign ram_we = xfer && (command == rbcfd_pkg::CMD_STORE) && (held < FULL_CNT);

  // ring storage
  rbcfd_ram #(
    .WIDTH (8),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_ptr),
    .wdata (rx_byte),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // frame decode from the captured bytes
  assign count    = {frame[4], frame[3], frame[2]};
  assign hdr_ok   = (frame[0] == rbcfd_pkg::HEADER_BYTE) &&
                    (frame[6] == rbcfd_pkg::TAIL_BYTE) &&
                    (frame[7] == rbcfd_pkg::TAIL_BYTE);
  assign in_range = (count >= 24'd1) && (count <= GAIN_MAX) && (count <= TABLE_MAX);
  assign amp_prod = 29'(frame[5]) * 29'(rbcfd_pkg::gain_recip(5'(count - 24'd1)));

  // read pointer advanced by one frame, wrapped in the update state
  assign rd_ptr_sum = {1'b0, rd_ptr} + FRAME_EXT;

  // sequencer, ring pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      rd_ptr   <= '0;
      wr_ptr   <= '0;
      held     <= '0;
      cnt      <= '0;
      cur_mode <= '0;
      cur_freq <= '0;
      cur_amp  <= '0;
      flags    <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (ram_we) begin
            wr_ptr <= (wr_ptr == LAST_ADDR) ? '0 : wr_ptr + PW'(1);
            held   <= held + HW'(1);
          end
          if (xfer && (command == rbcfd_pkg::CMD_POLL)) begin
            if (held >= FRAME_CNT) begin
              state <= ST_READ;
              cnt   <= '0;
            end else begin
              flags <= '0;
              done  <= 1'b1;
            end
          end
        end
        ST_READ: begin
          cnt <= cnt + 4'd1;
          if (cnt == 4'(rbcfd_pkg::FRAME_LEN)) begin
            state <= ST_CALC;
          end
        end
        ST_CALC: begin
          state <= ST_OUT;
        end
        ST_OUT: begin
          // settings update
          if (calc_valid) begin
            cur_mode <= calc_mode;
            if (calc_mode == rbcfd_pkg::MODE_FIXED) begin
              cur_freq <= freq_calc;
              cur_amp  <= rbcfd_pkg::FULL_AMPLITUDE;
            end else if (calc_mode == rbcfd_pkg::MODE_SCALED) begin
              cur_freq <= freq_calc;
              if (calc_range) begin
                cur_amp <= amp_calc;
              end
            end
          end
          // remove the frame
          if (held <= FRAME_CNT) begin
            rd_ptr <= '0;
            wr_ptr <= '0;
            held   <= '0;
          end else begin
            rd_ptr <= (rd_ptr_sum >= DEPTH_EXT) ? PW'(rd_ptr_sum - DEPTH_EXT)
                                                : PW'(rd_ptr_sum);
            held   <= held - FRAME_CNT;
          end
          flags.consumed <= 1'b1;
          flags.accepted <= calc_valid;
          flags.err      <= calc_valid && (calc_mode == rbcfd_pkg::MODE_SCALED) &&
                            !calc_range;
          done  <= 1'b1;
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // ring read address, one entry a cycle from the oldest byte
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      rd_addr <= rd_ptr;
    end else begin
      rd_addr <= (rd_addr == LAST_ADDR) ? '0 : rd_addr + PW'(1);
    end
  end

  // frame capture shift line, oldest byte ends at the front
  always_ff @(posedge clk) begin
    if ((state == ST_READ) && (cnt != 4'd0)) begin
      for (int i = 0; i < rbcfd_pkg::FRAME_LEN - 1; i++) begin
        frame[i] <= frame[i+1];
      end
      frame[rbcfd_pkg::FRAME_LEN-1] <= ram_rdata;
    end
  end

  // decode and multiply stage
  always_ff @(posedge clk) begin
    if (state == ST_CALC) begin
      freq_calc  <= 31'(count) * 31'(rbcfd_pkg::FREQ_SCALE);
      amp_calc   <= 17'(amp_prod >> rbcfd_pkg::GAIN_FRAC);
      calc_valid <= hdr_ok;
      calc_range <= in_range;
      calc_mode  <= frame[1];
    end
  end

  // result ports
  assign frequency_word = cur_freq;
  assign amplitude_word = cur_amp;
  assign mode_code      = cur_mode;
  assign frame_consumed = flags.consumed;
  assign frame_accepted = flags.accepted;
  assign index_error    = flags.err;
  assign fill_level     = 9'(held);

  // checks
  `ASSERT_IMP(a_done_idle, done, !busy)
  `ASSERT_IMP(a_held_max, 1'b1, held <= FULL_CNT)
  `ASSERT_IMP(a_accept_consumed, done && frame_accepted, frame_consumed)
  `ASSERT_IMP(a_err_mode, done && index_error, frame_accepted && (mode_code == rbcfd_pkg::MODE_SCALED))
  `ASSERT_NEXT(a_out_done, state == ST_OUT, done && frame_consumed)

endmodule

`default_nettype wire

FILE: dv/frame_result_checker.sv
// checker for the command frame decoder: predicts each poll report and compares it on the strobe
`timescale 1ns / 1ps

module frame_result_checker
  import rbcfd_pkg::*;
#(
  parameter int RING_DEPTH   = 256,
  parameter int GAIN_ENTRIES = 30
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic        command,
  input  logic [7:0]  rx_byte,
  input  logic        done,
  input  logic [30:0] frequency_word,
  input  logic [16:0] amplitude_word,
  input  logic [7:0]  mode_code,
  input  logic        frame_consumed,
  input  logic        frame_accepted,
  input  logic        index_error,
  input  logic [8:0]  fill_level,
  output int          failures,
  output int          pending
);

  // one poll report as it appears on the result ports
  typedef struct packed {
    logic [30:0] freq;
    logic [16:0] amp;
    logic [7:0]  mode;
    flags_t      flags;
    logic [8:0]  fill;
  } poll_report_t;

  // reciprocal calibration gains, unsigned q9.12, indexed by count - 1
  int unsigned gain_q12 [30] = '{
    248000,  260197,  280920,  299472,  323918,  348835,
    377905,  406974,  439363,  472030,  507904,  547310,
    587852,  622431,  661333,  705422,  755810,  793600,
    840901,  887944,  933647,  992000,  1049388, 1104139,
    1164917, 1220923, 1290407, 1333782, 1404602, 1483364
  };

  // predicted ring and settings
  logic [7:0]   ring [RING_DEPTH];
  int unsigned  rd_ptr, wr_ptr, held;
  logic [7:0]   mode_now;
  logic [30:0]  freq_now;
  logic [16:0]  amp_now;
  poll_report_t awaited_reports [$];

  int fail_count = 0;
  int awaited_count = 0;

  assign failures = fail_count;
  assign pending  = awaited_count;

  task automatic report_mismatch(input string msg);
    $display("%0t ns  mismatch: %s", $time, msg);
    fail_count++;
  endtask

  // a received byte goes into the ring unless it is full
  task automatic store_byte(input logic [7:0] b);
    if (held < RING_DEPTH) begin
      ring[wr_ptr] = b;
      wr_ptr = (wr_ptr + 1) % RING_DEPTH;
      held++;
    end
  endtask

  // poll: decode and remove the eight oldest bytes if held, then report settings
  task automatic decode_poll(output poll_report_t rep);
    logic [7:0]  f [FRAME_LEN];
    logic [23:0] count;
    logic [31:0] prod;
    logic [31:0] scaled;
    rep.flags = '0;
    if (held >= FRAME_LEN) begin
      for (int i = 0; i < FRAME_LEN; i++) f[i] = ring[(rd_ptr + i) % RING_DEPTH];
      rep.flags.consumed = 1'b1;
      if (f[0] == HEADER_BYTE && f[6] == TAIL_BYTE && f[7] == TAIL_BYTE) begin
        count = {f[4], f[3], f[2]};
        rep.flags.accepted = 1'b1;
        mode_now = f[1];
        if (mode_now == MODE_FIXED) begin
          freq_now = count * FREQ_SCALE;
          amp_now  = FULL_AMPLITUDE;
        end else if (mode_now == MODE_SCALED) begin
          freq_now = count * FREQ_SCALE;
          // counts outside the gain table (zero or past its end) keep the amplitude and raise the flag
          if (count >= 1 && count <= GAIN_ENTRIES && count <= 30) begin
            prod    = f[5] * gain_q12[count - 1];
            scaled  = prod >> GAIN_FRAC;
            amp_now = scaled[16:0];
          end else begin
            rep.flags.err = 1'b1;
          end
        end
      end
      // emptying the ring puts both pointers back to zero
      if (held <= FRAME_LEN) begin
        rd_ptr = 0;
        wr_ptr = 0;
        held   = 0;
      end else begin
        rd_ptr = (rd_ptr + FRAME_LEN) % RING_DEPTH;
        held   = held - FRAME_LEN;
      end
    end
    rep.freq = freq_now;
    rep.amp  = amp_now;
    rep.mode = mode_now;
    rep.fill = held[8:0];
  endtask

  task automatic compare_report(input poll_report_t got, input poll_report_t want);
    if (got.freq !== want.freq)
      report_mismatch($sformatf("frequency_word got %0d, expected %0d", got.freq, want.freq));
    if (got.amp !== want.amp)
      report_mismatch($sformatf("amplitude_word got %0d, expected %0d", got.amp, want.amp));
    if (got.mode !== want.mode)
      report_mismatch($sformatf("mode_code got %0d, expected %0d", got.mode, want.mode));
    if (got.flags.consumed !== want.flags.consumed)
      report_mismatch($sformatf("frame_consumed got %0b, expected %0b",
                                got.flags.consumed, want.flags.consumed));
    if (got.flags.accepted !== want.flags.accepted)
      report_mismatch($sformatf("frame_accepted got %0b, expected %0b",
                                got.flags.accepted, want.flags.accepted));
    if (got.flags.err !== want.flags.err)
      report_mismatch($sformatf("index_error got %0b, expected %0b",
                                got.flags.err, want.flags.err));
    if (got.fill !== want.fill)
      report_mismatch($sformatf("fill_level got %0d, expected %0d", got.fill, want.fill));
  endtask

  // results are checked before a transfer at the same edge is predicted
  always @(posedge clk) begin
    poll_report_t got;
    poll_report_t want;
    if (rst) begin
      rd_ptr   = 0;
      wr_ptr   = 0;
      held     = 0;
      mode_now = '0;
      freq_now = '0;
      amp_now  = '0;
      awaited_reports.delete();
    end else begin
      if (done) begin
        got.freq           = frequency_word;
        got.amp            = amplitude_word;
        got.mode           = mode_code;
        got.flags.consumed = frame_consumed;
        got.flags.accepted = frame_accepted;
        got.flags.err      = index_error;
        got.fill           = fill_level;
        if (awaited_reports.size() == 0) begin
          report_mismatch("result strobe with no poll awaiting a report");
        end else begin
          want = awaited_reports.pop_front();
          compare_report(got, want);
        end
      end
      if (start && !busy) begin
        if (command == CMD_STORE) begin
          store_byte(rx_byte);
        end else begin
          decode_poll(want);
          awaited_reports.push_back(want);
        end
      end
    end
    awaited_count <= awaited_reports.size();
  end

endmodule

FILE: dv/testbench.sv
// top of the command frame decoder testbench: clock, reset, byte and poll stimulus, verdict
`timescale 1ns / 1ps

module testbench;
  import rbcfd_pkg::*;

  localparam int RING_DEPTH = 256;
  localparam int ITEMS      = 1150;
  localparam int LIMIT      = 500000;

  logic        clk     = 1'b0;
  logic        rst     = 1'b1;
  logic        start   = 1'b0;
  logic        command = CMD_STORE;
  logic [7:0]  rx_byte = '0;
  logic        busy;
  logic        done;
  logic [30:0] frequency_word;
  logic [16:0] amplitude_word;
  logic [7:0]  mode_code;
  logic        frame_consumed;
  logic        frame_accepted;
  logic        index_error;
  logic [8:0]  fill_level;

  int failures;
  int pending;
  int cycle_count;

  // stimulus bookkeeping
  int items_sent   = 0;
  int held_guess   = 0;
  bit calm         = 1'b0;
  bit flooded      = 1'b0;

  ring_buffered_command_frame_decoder #(
    .RING_DEPTH  (RING_DEPTH),
    .GAIN_ENTRIES(30)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .command       (command),
    .rx_byte       (rx_byte),
    .done          (done),
    .frequency_word(frequency_word),
    .amplitude_word(amplitude_word),
    .mode_code     (mode_code),
    .frame_consumed(frame_consumed),
    .frame_accepted(frame_accepted),
    .index_error   (index_error),
    .fill_level    (fill_level)
  );

  frame_result_checker #(
    .RING_DEPTH  (RING_DEPTH),
    .GAIN_ENTRIES(30)
  ) u_checker (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .command       (command),
    .rx_byte       (rx_byte),
    .done          (done),
    .frequency_word(frequency_word),
    .amplitude_word(amplitude_word),
    .mode_code     (mode_code),
    .frame_consumed(frame_consumed),
    .frame_accepted(frame_accepted),
    .index_error   (index_error),
    .fill_level    (fill_level),
    .failures      (failures),
    .pending       (pending)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 0;
  end

  // run limit
  initial begin
    for (cycle_count = 0; cycle_count < LIMIT; cycle_count++) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  // mostly back to back, sometimes short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  task automatic pace();
    int g;
    g = gap_len();
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // one transfer; start stays high afterwards unless the next pace drops it
  task automatic transfer(input logic cmd, input logic [7:0] b);
    pace();
    start   <= 1'b1;
    command <= cmd;
    rx_byte <= b;
    do @(posedge clk); while (busy);
    items_sent++;
    if (cmd == CMD_STORE) begin
      if (held_guess < RING_DEPTH) held_guess++;
    end else if (held_guess >= FRAME_LEN) begin
      held_guess -= FRAME_LEN;
    end
  endtask

  task automatic poll();
    transfer(CMD_POLL, 8'($urandom));
  endtask

  // frame bytes packed oldest first in the low byte
  task automatic send_frame(input logic [63:0] f);
    for (int i = 0; i < FRAME_LEN; i++) transfer(CMD_STORE, f[8*i +: 8]);
  endtask

  function automatic logic [63:0] random_frame();
    logic [7:0]  hdr, md, vpp, t6, t7;
    logic [23:0] cnt;
    int r;
    hdr = ($urandom_range(0, 15) == 0) ? 8'($urandom) : HEADER_BYTE;
    r = $urandom_range(0, 19);
    if (r < 7)       md = MODE_FIXED;
    else if (r < 16) md = MODE_SCALED;
    else             md = 8'($urandom);
    // counts lean towards the gain table and its edges
    r = $urandom_range(0, 9);
    case (r)
      0, 1, 2, 3, 4: cnt = 24'($urandom_range(1, 30));
      5:             cnt = '0;
      6:             cnt = 24'($urandom_range(31, 300));
      7:             cnt = 24'hffffff;
      default:       cnt = 24'($urandom);
    endcase
    r = $urandom_range(0, 5);
    if (r == 0)      vpp = 8'h00;
    else if (r == 1) vpp = 8'hff;
    else             vpp = 8'($urandom);
    t6 = ($urandom_range(0, 15) == 0) ? 8'($urandom) : TAIL_BYTE;
    t7 = ($urandom_range(0, 15) == 0) ? 8'($urandom) : TAIL_BYTE;
    return {t7, t6, vpp, cnt, md, hdr};
  endfunction

  // hold the sender until every report has come back
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // pad with filler so the next frame starts on a frame boundary
  task automatic realign();
    while (held_guess % FRAME_LEN != 0) transfer(CMD_STORE, 8'($urandom));
  endtask

  // overfill the ring so bytes get dropped, then poll it down below one frame
  task automatic flood_ring();
    repeat (34) send_frame(random_frame());
    while (held_guess >= FRAME_LEN) poll();
    poll();
  endtask

  initial begin
    int pick;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: poll on an empty ring
    poll();
    // largest count in mode 1, exactly eight held
    send_frame({TAIL_BYTE, TAIL_BYTE, 8'h00, 24'hffffff, MODE_FIXED, HEADER_BYTE});
    poll();
    // last gain entry with full peak-to-peak in mode 2
    send_frame({TAIL_BYTE, TAIL_BYTE, 8'hff, 24'd30, MODE_SCALED, HEADER_BYTE});
    poll();
    // count zero in mode 2 keeps the amplitude
    send_frame({TAIL_BYTE, TAIL_BYTE, 8'h80, 24'd0, MODE_SCALED, HEADER_BYTE});
    poll();
    drain();

    // random frames, noise, bare polls and one ring overflow
    while (items_sent < ITEMS) begin
      calm = ($urandom_range(0, 7) == 0);
      pick = $urandom_range(0, 99);
      if (!flooded && items_sent > 500) begin
        flood_ring();
        flooded = 1'b1;
      end else if (pick < 65) begin
        if ($urandom_range(0, 4) != 0) realign();
        send_frame(random_frame());
        if ($urandom_range(0, 5) == 0) send_frame(random_frame());
        poll();
      end else if (pick < 80) begin
        repeat ($urandom_range(1, 7)) transfer(CMD_STORE, 8'($urandom));
        if ($urandom_range(0, 1) == 0) poll();
      end else if (pick < 96) begin
        repeat ($urandom_range(1, 3)) poll();
      end else begin
        drain();
      end
    end

    calm = 1'b0;
    drain();
    repeat (20) @(posedge clk);
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+src
src/rbcfd_pkg.sv
src/rbcfd_ram.sv
src/ring_buffered_command_frame_decoder.sv
dv/frame_result_checker.sv
dv/testbench.sv
